>>> sv/kmh_pkg.sv
// Shared constants, types and helper functions for the key matrix to HID report block.
package kmh_pkg;

  localparam int ROWS_DEF   = 5;
  localparam int COLS_DEF   = 8;
  localparam int ROW_STRIDE = 8;
  localparam int KEYS       = 40;
  localparam int SLOTS      = 6;
  localparam int SLOT_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 6;

  localparam logic FUNC_MAP  = 1'b0;
  localparam logic FUNC_SNAP = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    byte_t modifier;
    byte_t keycode;
  } map_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT
  } scan_state_t;

  // Map store depth: rows at a stride of eight, never beyond the 40-bit matrix.
  function automatic int map_depth(int rows);
    int d;
    d = rows * ROW_STRIDE;
    return (d > KEYS) ? KEYS : d;
  endfunction

  // Matrix bits that belong to a real row and column.
  function automatic logic [KEYS-1:0] key_mask(int rows, int cols);
    logic [KEYS-1:0] m;
    m = '0;
    for (int k = 0; k < KEYS; k++) begin
      if ((k / ROW_STRIDE) < rows && (k % ROW_STRIDE) < cols) begin
        m[k] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

>>> sv/kmh_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module kmh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 40,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/kmh_map.sv
// Key map store: RAM plus per-entry written flags so unwritten entries read as zero.
module kmh_map import kmh_pkg::*; #(
  parameter int DEPTH = map_depth(ROWS_DEF),
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  map_entry_t       wr_entry,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output map_entry_t       rd_entry
);

  logic [DEPTH-1:0] written_r;
  logic             rd_written_r;
  logic             wr_hit;
  logic [AW-1:0]    wr_addr;
  logic [2*BYTE_W-1:0] ram_q;

  // indexes past the store are dropped
  assign wr_hit  = wr_en && ({1'b0, wr_idx} < (IDX_W+1)'(DEPTH));
  assign wr_addr = wr_idx[AW-1:0];

  kmh_ram #(
    .WIDTH (2*BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_hit),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (wr_hit) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written_r <= written_r[rd_addr];
      end
    end
  end

  assign rd_entry = rd_written_r ? map_entry_t'(ram_q) : '0;

endmodule

>>> sv/kmh_scan.sv
// Snapshot compare, map walk sequencer, report accumulation and output register.
module kmh_scan import kmh_pkg::*; #(
  parameter int ROWS  = ROWS_DEF,
  parameter int COLS  = COLS_DEF,
  parameter int DEPTH = map_depth(ROWS),
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_accept,
  input  logic            in_func,
  input  logic [KEYS-1:0] in_key_matrix,
  output logic            in_stall,
  output logic            rd_en,
  output logic [AW-1:0]   rd_addr,
  input  map_entry_t      rd_entry,
  output logic            out_valid,
  input  logic            out_stall,
  output byte_t           out_modifier_byte,
  output byte_t           out_keycode_1,
  output byte_t           out_keycode_2,
  output byte_t           out_keycode_3,
  output byte_t           out_keycode_4,
  output byte_t           out_keycode_5,
  output byte_t           out_keycode_6
);

  localparam logic [KEYS-1:0] MASK = key_mask(ROWS, COLS);

  scan_state_t state_r, state_nxt;
  logic [KEYS-1:0]  prev_r;
  logic [DEPTH-1:0] prev_lo;
  logic [KEYS-1:0]  snap;
  logic             start;
  logic             load_out;
  logic [AW-1:0]    addr_r;
  logic             pend_r;
  logic [AW-1:0]    pend_idx_r;
  logic             hit;
  byte_t            mod_acc_r;
  byte_t [SLOTS-1:0] slot_r;
  logic [SLOT_W-1:0] ptr_r;
  logic             out_valid_r;
  byte_t            out_mod_r;
  byte_t [SLOTS-1:0] out_slot_r;

  assign snap    = in_key_matrix & MASK;
  assign start   = in_accept && (in_func == FUNC_SNAP) && (snap != prev_r);
  assign prev_lo = prev_r[DEPTH-1:0];
  assign hit     = pend_r && prev_lo[pend_idx_r];

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        rd_en = 1'b1;
        if (addr_r == AW'(DEPTH-1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      addr_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= rd_en;
      if (start) begin
        prev_r <= snap;
        addr_r <= '0;
      end else if (rd_en) begin
        addr_r <= addr_r + AW'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= addr_r;
    if (start) begin
      mod_acc_r <= '0;
      slot_r    <= '0;
      ptr_r     <= '0;
    end else if (hit) begin
      mod_acc_r     <= mod_acc_r | rd_entry.modifier;
      slot_r[ptr_r] <= rd_entry.keycode;
      // last slot sticks and takes every later key
      if (ptr_r < SLOT_W'(SLOTS-1) && rd_entry.keycode != '0) begin
        ptr_r <= ptr_r + SLOT_W'(1);
      end
    end
    if (load_out) begin
      out_mod_r  <= mod_acc_r;
      out_slot_r <= slot_r;
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign rd_addr           = addr_r;
  assign out_valid         = out_valid_r;
  assign out_modifier_byte = out_mod_r;
  assign out_keycode_1     = out_slot_r[0];
  assign out_keycode_2     = out_slot_r[1];
  assign out_keycode_3     = out_slot_r[2];
  assign out_keycode_4     = out_slot_r[3];
  assign out_keycode_5     = out_slot_r[4];
  assign out_keycode_6     = out_slot_r[5];

endmodule

>>> sv/key_matrix_to_hid_report_top.sv
// Top level of the key matrix to boot keyboard report converter.
// A map-write transfer (in_func = 0) stores one modifier/keycode pair in the
// key map with no input stall; indexes at or past the map depth (ROWS*8,
// at most 40) are dropped. A snapshot transfer (in_func = 1) masks off bits
// outside ROWS x COLS and compares with the last kept snapshot: if equal, it
// gives no report and no input stall; if not, the block keeps it and walks
// the key map one entry per cycle through the map RAM's single read port,
// then drains the last read and loads the report into a free output register.
// The input side stalls from the accepted snapshot until its report is loaded
// into the output register; a finished report sits in the output register
// while new transfers are taken. The report ORs the modifier
// bytes of all pressed keys and fills six keycode slots in key order; a zero
// keycode does not advance the slot, and once the sixth slot is reached every
// later pressed key overwrites it. Map entries clear to zero at reset through
// per-entry written flags, so no clearing pass is needed after reset.
module key_matrix_to_hid_report_top import kmh_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic [IDX_W-1:0] in_key_index,
  input  byte_t            in_map_modifier,
  input  byte_t            in_map_keycode,
  input  logic [KEYS-1:0]  in_key_matrix,
  output logic             out_valid,
  input  logic             out_stall,
  output byte_t            out_modifier_byte,
  output byte_t            out_keycode_1,
  output byte_t            out_keycode_2,
  output byte_t            out_keycode_3,
  output byte_t            out_keycode_4,
  output byte_t            out_keycode_5,
  output byte_t            out_keycode_6
);

  localparam int DEPTH = map_depth(ROWS);
  localparam int AW    = $clog2(DEPTH);

  logic          in_accept;
  logic          map_wr;
  map_entry_t    wr_entry;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  map_entry_t    rd_entry;

  // transfer on the input channel
  assign in_accept = in_valid && !in_stall;
  assign map_wr    = in_accept && (in_func == FUNC_MAP);
  assign wr_entry  = '{modifier: in_map_modifier, keycode: in_map_keycode};

  kmh_map #(
    .DEPTH (DEPTH)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (map_wr),
    .wr_idx   (in_key_index),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  kmh_scan #(
    .ROWS  (ROWS),
    .COLS  (COLS),
    .DEPTH (DEPTH)
  ) u_scan (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_accept         (in_accept),
    .in_func           (in_func),
    .in_key_matrix     (in_key_matrix),
    .in_stall          (in_stall),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_entry          (rd_entry),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_modifier_byte (out_modifier_byte),
    .out_keycode_1     (out_keycode_1),
    .out_keycode_2     (out_keycode_2),
    .out_keycode_3     (out_keycode_3),
    .out_keycode_4     (out_keycode_4),
    .out_keycode_5     (out_keycode_5),
    .out_keycode_6     (out_keycode_6)
  );

endmodule

>>> sv/kmh_check.sv
// Port-level checker for the key matrix to HID report block, bound to the top level.
module kmh_check import kmh_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             in_func,
  input logic [IDX_W-1:0] in_key_index,
  input byte_t            in_map_modifier,
  input byte_t            in_map_keycode,
  input logic [KEYS-1:0]  in_key_matrix,
  input logic             out_valid,
  input logic             out_stall,
  input byte_t            out_modifier_byte,
  input byte_t            out_keycode_1,
  input byte_t            out_keycode_2,
  input byte_t            out_keycode_3,
  input byte_t            out_keycode_4,
  input byte_t            out_keycode_5,
  input byte_t            out_keycode_6
);

  a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_func) && $stable(in_key_index)
      && $stable(in_map_modifier) && $stable(in_map_keycode) && $stable(in_key_matrix))
    else $error("input transfer changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("report dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_modifier_byte) && $stable(out_keycode_1)
      && $stable(out_keycode_2) && $stable(out_keycode_3) && $stable(out_keycode_4)
      && $stable(out_keycode_5) && $stable(out_keycode_6))
    else $error("report changed while stalled");

  a_map_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == FUNC_MAP) |=> !in_stall)
    else $error("map write did not finish in one cycle");

  a_report_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("report appeared without a map walk");

endmodule

bind key_matrix_to_hid_report_top kmh_check u_kmh_check (.*);
